[src/decimal_digit_permuter_defines.svh]
// assertion macros for the decimal digit permuter
// expects clk and arst_n in the scope of each use
`ifndef DECIMAL_DIGIT_PERMUTER_DEFINES_SVH
`define DECIMAL_DIGIT_PERMUTER_DEFINES_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define DDP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DDP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DDP_ASSERT(lbl, prop, msg)
`define DDP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[src/ddp_pkg.sv]
// types, constants and helpers shared by the decimal digit permuter
// no dependencies
package ddp_pkg;

	localparam int DIGIT_COUNT = 7;
	localparam int VALUE_W     = 24;
	localparam int DIGIT_W     = 4;
	localparam int IDX_W       = $clog2(DIGIT_COUNT);
	localparam int ACC_W       = $clog2(10 ** DIGIT_COUNT);

	// reciprocal multiply: exact quotient for any VALUE_W-bit value and divisor from 2 up to 15
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = 28;
	localparam int RECIP_ONE   = 2 ** RECIP_SHIFT;
	localparam int RADIX_DEC   = 10;

	typedef logic [DIGIT_W-1:0]    digit_t;
	typedef digit_t [DIGIT_COUNT-1:0] digits_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef idx_t [DIGIT_COUNT-2:0] sels_t;
	typedef logic [VALUE_W-1:0]    value_t;

	typedef struct packed {
		value_t quo;
		digit_t rem;
	} divmod_t;

	typedef struct packed {
		logic    valid;
		digits_t dig;
		sels_t   sel;
	} perm_word_t;

	typedef struct packed {
		logic    valid;
		digits_t dig;
	} comb_word_t;

	typedef struct packed {
		logic   valid;
		value_t value;
	} res_word_t;

	// quotient and remainder of x by a small constant d, m = ceil(2^RECIP_SHIFT / d)
	function automatic divmod_t divmod_small(input value_t x, input logic [RECIP_W-1:0] m,
			input digit_t d);
		logic [VALUE_W+RECIP_W-1:0] prod;
		divmod_t r;
		prod  = {{RECIP_W{1'b0}}, x} * {{VALUE_W{1'b0}}, m};
		r.quo = prod[RECIP_SHIFT +: VALUE_W];
		r.rem = DIGIT_W'(x - value_t'(r.quo * value_t'(d)));
		return r;
	endfunction

endpackage

[src/ddp_req_if.sv]
// request channel: value and key words into the permuter
// depends on ddp_pkg
interface ddp_req_if import ddp_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t digit_value;
	value_t perm_key;

	modport source (output valid, output digit_value, output perm_key, input ready);
	modport sink (input valid, input digit_value, input perm_key, output ready);
endinterface

[src/ddp_res_if.sv]
// result channel: permuted value words out of the permuter
// depends on ddp_pkg
interface ddp_res_if import ddp_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t permuted_value;

	modport source (output valid, output permuted_value, input ready);
	modport sink (input valid, input permuted_value, output ready);
endinterface

[src/ddp_split.sv]
// digit split: one decimal digit per stage, and one factorial-base key digit per stage but the last
// depends on ddp_pkg
module ddp_split import ddp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       in_valid,
	input  value_t     digit_value,
	input  value_t     perm_key,
	output perm_word_t word
);

	localparam logic [RECIP_W-1:0] DEC_RECIP = RECIP_W'((RECIP_ONE + RADIX_DEC - 1) / RADIX_DEC);

	logic    valid_s [DIGIT_COUNT];
	value_t  val_s   [DIGIT_COUNT];
	value_t  key_s   [DIGIT_COUNT-1];
	digits_t dig_s   [DIGIT_COUNT];
	sels_t   sel_s   [DIGIT_COUNT];

	for (genvar j = 0; j < DIGIT_COUNT; j++) begin : g_stage
		logic    vin;
		value_t  vv;
		digits_t dd, dn;
		sels_t   ss, sn;
		divmod_t vq;

		if (j == 0) begin : g_first
			assign vin = in_valid;
			assign vv  = digit_value;
			assign dd  = '0;
			assign ss  = '0;
		end else begin : g_next
			assign vin = valid_s[j-1];
			assign vv  = val_s[j-1];
			assign dd  = dig_s[j-1];
			assign ss  = sel_s[j-1];
		end

		assign vq = divmod_small(vv, DEC_RECIP, DIGIT_W'(RADIX_DEC));

		always_comb begin
			dn = dd;
			dn[DIGIT_COUNT-1-j] = vq.rem;
		end

		if (j < DIGIT_COUNT - 1) begin : g_key
			localparam int KEY_RADIX = j + 2;
			localparam logic [RECIP_W-1:0] KEY_RECIP =
				RECIP_W'((RECIP_ONE + KEY_RADIX - 1) / KEY_RADIX);
			value_t  kk;
			divmod_t kq;

			if (j == 0) begin : g_kfirst
				assign kk = perm_key;
			end else begin : g_knext
				assign kk = key_s[j-1];
			end

			assign kq = divmod_small(kk, KEY_RECIP, DIGIT_W'(KEY_RADIX));

			always_comb begin
				sn = ss;
				sn[DIGIT_COUNT-2-j] = IDX_W'(kq.rem);
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					key_s[j] <= kq.quo;
				end
			end
		end else begin : g_nokey
			assign sn = ss;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (adv) begin
				valid_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				val_s[j] <= vq.quo;
				dig_s[j] <= dn;
				sel_s[j] <= sn;
			end
		end
	end

	assign word.valid = valid_s[DIGIT_COUNT-1];
	assign word.dig   = dig_s[DIGIT_COUNT-1];
	assign word.sel   = sel_s[DIGIT_COUNT-1];

endmodule

[src/ddp_permute.sv]
// permutation: one position settled per stage, rotating the digits between
// depends on ddp_pkg
module ddp_permute import ddp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  perm_word_t in_word,
	output comb_word_t out_word
);

	logic    valid_s [DIGIT_COUNT-1];
	digits_t dig_s   [DIGIT_COUNT-1];
	sels_t   sel_s   [DIGIT_COUNT-1];

	for (genvar i = 0; i < DIGIT_COUNT - 1; i++) begin : g_stage
		logic    vin;
		digits_t dd, dn;
		sels_t   ss;
		idx_t    src;

		if (i == 0) begin : g_first
			assign vin = in_word.valid;
			assign dd  = in_word.dig;
			assign ss  = in_word.sel;
		end else begin : g_next
			assign vin = valid_s[i-1];
			assign dd  = dig_s[i-1];
			assign ss  = sel_s[i-1];
		end

		assign src = IDX_W'(i) + ss[i];

		always_comb begin
			for (int k = 0; k < DIGIT_COUNT; k++) begin
				if (k == i) begin
					dn[k] = dd[src];
				end else if (k > i && k <= int'(src)) begin
					dn[k] = dd[k-1];
				end else begin
					dn[k] = dd[k];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (adv) begin
				valid_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dig_s[i] <= dn;
				sel_s[i] <= ss;
			end
		end
	end

	assign out_word.valid = valid_s[DIGIT_COUNT-2];
	assign out_word.dig   = dig_s[DIGIT_COUNT-2];

endmodule

[src/ddp_combine.sv]
// recombination: one decimal digit folded into the binary value per stage
// depends on ddp_pkg
module ddp_combine import ddp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  comb_word_t in_word,
	output res_word_t  out_word
);

	logic             valid_s [DIGIT_COUNT];
	digits_t          dig_s   [DIGIT_COUNT];
	logic [ACC_W-1:0] acc_s   [DIGIT_COUNT];

	for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_stage
		logic             vin;
		digits_t          dd;
		logic [ACC_W-1:0] aa, an;

		if (k == 0) begin : g_first
			assign vin = in_word.valid;
			assign dd  = in_word.dig;
			assign aa  = '0;
		end else begin : g_next
			assign vin = valid_s[k-1];
			assign dd  = dig_s[k-1];
			assign aa  = acc_s[k-1];
		end

		// times ten as shift and add
		assign an = ACC_W'({aa, 3'b000}) + ACC_W'({aa, 1'b0}) + ACC_W'(dd[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dig_s[k] <= dd;
				acc_s[k] <= an;
			end
		end
	end

	assign out_word.valid = valid_s[DIGIT_COUNT-1];
	assign out_word.value = VALUE_W'(acc_s[DIGIT_COUNT-1]);

endmodule

[src/ddp_outbuf.sv]
// output register with skid stage, decouples pipeline advance from result ready
// depends on ddp_pkg, ddp_res_if and the assertion macro header
`include "decimal_digit_permuter_defines.svh"

module ddp_outbuf import ddp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  res_word_t        in_word,
	output logic             in_ready,
	ddp_res_if.source        result
);

	logic   out_valid_q;
	value_t out_data_q;
	logic   skid_valid_q;
	value_t skid_data_q;

	assign in_ready              = !skid_valid_q;
	assign result.valid          = out_valid_q;
	assign result.permuted_value = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				out_data_q   <= skid_data_q;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_word.valid;
				out_data_q  <= in_word.value;
			end
		end else if (in_word.valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
			skid_data_q  <= in_word.value;
		end
	end

	`DDP_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid word without output word")
	`DDP_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_q) |-> $past(out_valid_q && !result.ready), "skid filled without stall")
	`DDP_ASSERT(a_skid_drain, skid_valid_q && result.ready |=> out_valid_q && !skid_valid_q, "skid word not moved out")
	`DDP_ASSERT_ALWAYS(a_reset_empty, !arst_n && $past(!arst_n) |-> !out_valid_q && !skid_valid_q, "buffer not empty in reset")

endmodule

[src/decimal_digit_permuter.sv]
// top level of the decimal digit permuter
// depends on ddp_pkg, ddp_req_if, ddp_res_if, ddp_split, ddp_permute, ddp_combine, ddp_outbuf
//
// request carries digit_value and perm_key; result carries permuted_value.
// a word is taken when valid and ready are both high at a rising edge of clk.
// the value's low DIGIT_COUNT decimal digits are reordered by the key read in
// factorial base, then folded back into a binary value.
// pipeline: 3*DIGIT_COUNT - 1 register stages up to the output register:
// DIGIT_COUNT split stages, DIGIT_COUNT-1 permute stages and DIGIT_COUNT recombine
// stages, each two reciprocal multiplies (one in the last split stage), one digit
// mux or one shift-add.
// throughput: one word per cycle while result.ready stays high.
// stall: the output register plus a one-word skid stage take the last word; while
// the skid stage is full the whole pipeline holds and request.ready is low.
// request.ready comes from a register only, never from result.ready.
// reset: arst_n clears every valid bit and both output stages; no memory to clear.
module decimal_digit_permuter import ddp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	ddp_req_if.sink   request,
	ddp_res_if.source result
);

	logic       adv;
	perm_word_t split_word;
	comb_word_t perm_word;
	res_word_t  comb_word;

	assign request.ready = adv;

	ddp_split u_split (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (request.valid),
		.digit_value (request.digit_value),
		.perm_key    (request.perm_key),
		.word        (split_word)
	);

	ddp_permute u_permute (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_word  (split_word),
		.out_word (perm_word)
	);

	ddp_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_word  (perm_word),
		.out_word (comb_word)
	);

	ddp_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (comb_word),
		.in_ready (adv),
		.result   (result)
	);

endmodule
